@@ rtl/gcd_pkg.sv @@
// Package for the great-circle distance unit: formats, constants and table functions.
package gcd_pkg;

	// Number of CORDIC iterations in each sine/cosine and arccosine unit (12 to 40).
	localparam int TRIG_STAGES = 24;

	// Datapath widths: x/y in Q30, angles in Q60, square-root work registers, cosine sum.
	localparam int XW = 34;
	localparam int ZW = 64;
	localparam int QW = 62;
	localparam int CW = 32;

	// Square root of a 61-bit radicand: one result bit per step.
	localparam int SQ_STEPS = 31;

	localparam logic signed [ZW-1:0] PI_Q60 = 64'sh3243F6A8885A308D;

	// Degrees scaled by 2^24.
	localparam logic signed [35:0] DEG_FULL    = 36'sd6039797760;
	localparam logic signed [35:0] DEG_HALF    = 36'sd3019898880;
	localparam logic signed [35:0] DEG_QUARTER = 36'sd1509949440;

	// Radians Q60 per degree * 2^24, rounded.
	localparam logic signed [31:0] DEG_TO_RAD =
		32'((64'h3243F6A8885A308D + 64'd1509949440) / 64'd3019898880);

	// Meters * 2^8 per radian, scaled by 2^3, and the half circumference.
	localparam logic [33:0] SCALE_Q  = 34'd13037972938;
	localparam logic [32:0] DIST_MAX = 33'd5120000000;

	// Unsigned quotient by shift and subtract, for the elaboration-time tables.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		int i;
		q = '0;
		r = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in Q60 by the truncated alternating series.
	function automatic logic signed [ZW-1:0] atan_q60(input int idx);
		logic signed [ZW-1:0] acc;
		logic [63:0] term;
		int k;
		acc = '0;
		if (idx == 0) begin
			acc = PI_Q60 >>> 2;
		end else begin
			for (k = 0; 60 - (2 * k + 1) * idx >= 0; k++) begin
				term = udiv64(64'd1 << (60 - (2 * k + 1) * idx), 64'(2 * k + 1));
				if (k[0])
					acc = acc - $signed(term);
				else
					acc = acc + $signed(term);
			end
		end
		return acc;
	endfunction

	// CORDIC start value: square root of the product of 1/(1+4^-i), in Q30.
	function automatic logic [XW-1:0] cordic_gain();
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		int i;
		p = 64'd1 << 60;
		for (i = 0; i < TRIG_STAGES && i < 31; i++)
			p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
		v = p;
		r = '0;
		b = 64'd1 << 62;
		for (i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return XW'(r);
	endfunction

	localparam logic [XW-1:0] GAIN_Q30 = cordic_gain();

endpackage

@@ rtl/great_circle_distance_unit.sv @@
// Great-circle distance unit: fully pipelined law-of-cosines datapath with CORDIC trig.
//
// channel | dir | tdata bits (low first)                                   | size
// s_*     | in  | from_lat[31:0] from_lon[64:32] to_lat[96:65] to_lon[129:97] | 136
// m_*     | out | distance[32:0]                                           | 40
//
// One pair enters per cycle while the skid register is empty; the pipe depth is set by the two
// CORDIC chains (one iteration per stage) and the 31-step square-root pipe.
// Reset clears only valid bits and the output/skid flags; payload is not reset.
// A stalled result parks in the output register, the next one in a skid register;
// the whole pipe halts only while the skid register is full.
module great_circle_distance_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// from_lat[31:0], from_lon[64:32], to_lat[96:65], to_lon[129:97], zero pad
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// distance[32:0], zero pad
	output logic [39:0]  m_tdata
);
	import gcd_pkg::*;

	localparam int N   = TRIG_STAGES;
	localparam int LAT = 2 * N + 44;

	localparam logic signed [34:0] ONE_S = 35'sd1073741824;

	// Fold an angle in [-180, 180) to [-90, 90]; top bit flags a cosine sign flip.
	function automatic logic [32:0] fold_ang(input logic signed [35:0] a);
		logic signed [35:0] r;
		logic f;
		r = a;
		f = 1'b0;
		if (a > DEG_QUARTER) begin
			r = DEG_HALF - a;
			f = 1'b1;
		end else if (a < -DEG_QUARTER) begin
			r = -DEG_HALF - a;
			f = 1'b1;
		end
		return {f, r[31:0]};
	endfunction

	logic            en;
	logic [LAT-1:0]  pipe_v_q;
	logic            ov_q;
	logic            sk_v_q;
	logic [32:0]     out_q;
	logic [32:0]     sk_q;

	logic signed [31:0] from_lat;
	logic signed [32:0] from_lon;
	logic signed [31:0] to_lat;
	logic signed [32:0] to_lon;

	assign from_lat = s_tdata[31:0];
	assign from_lon = s_tdata[64:32];
	assign to_lat   = s_tdata[96:65];
	assign to_lon   = s_tdata[129:97];

	// Halt every stage only while the skid register holds a result.
	assign en       = !sk_v_q;
	assign s_tready = en;

	// Stage 1: capture, longitude difference, equal-point check.
	logic signed [31:0] lat0_s1, lat1_s1;
	logic signed [33:0] dlon_s1;
	logic               eq_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			lat0_s1 <= from_lat;
			lat1_s1 <= to_lat;
			dlon_s1 <= 34'(to_lon) - 34'(from_lon);
			eq_s1   <= (from_lat == to_lat) && (from_lon == to_lon);
		end
	end

	// Stage 2: reduce the longitude difference to [-180, 180).
	logic signed [35:0] ang_s2 [3];
	logic               eq_s2;
	logic signed [35:0] dl;

	assign dl = 36'(dlon_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s2[0] <= 36'(lat0_s1);
			ang_s2[1] <= 36'(lat1_s1);
			if (dl >= DEG_HALF)
				ang_s2[2] <= dl - DEG_FULL;
			else if (dl < -DEG_HALF)
				ang_s2[2] <= dl + DEG_FULL;
			else
				ang_s2[2] <= dl;
			eq_s2 <= eq_s1;
		end
	end

	// Stage 3: fold to the right half plane.
	logic signed [31:0] r_s3 [3];
	logic               flip_s3 [3];
	logic               eq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int u = 0; u < 3; u++) begin
				{flip_s3[u], r_s3[u]} <= fold_ang(ang_s2[u]);
			end
			eq_s3 <= eq_s2;
		end
	end

	// Stage 4 and rotation chain: three sine/cosine CORDIC units.
	logic signed [XW-1:0] rx_s [3][N+1];
	logic signed [XW-1:0] ry_s [3][N+1];
	logic signed [ZW-1:0] rz_s [3][N+1];
	logic                 rf_s [3][N+1];
	logic                 req_s [N+1];

	always_ff @(posedge clk) begin
		if (en)
			req_s[0] <= eq_s3;
	end

	for (genvar u = 0; u < 3; u++) begin : g_rot_u
		// Load the start vector and the angle in radians.
		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[u][0] <= $signed(GAIN_Q30);
				ry_s[u][0] <= '0;
				rz_s[u][0] <= r_s3[u] * DEG_TO_RAD;
				rf_s[u][0] <= flip_s3[u];
			end
		end

		for (genvar k = 0; k < N; k++) begin : g_rot_k
			localparam logic signed [ZW-1:0] ATN = atan_q60(k);
			logic signed [XW-1:0] xn, yn;
			logic signed [ZW-1:0] zn;

			// Rotate toward zero residual angle.
			always_comb begin
				if (!rz_s[u][k][ZW-1]) begin
					xn = rx_s[u][k] - (ry_s[u][k] >>> k);
					yn = ry_s[u][k] + (rx_s[u][k] >>> k);
					zn = rz_s[u][k] - ATN;
				end else begin
					xn = rx_s[u][k] + (ry_s[u][k] >>> k);
					yn = ry_s[u][k] - (rx_s[u][k] >>> k);
					zn = rz_s[u][k] + ATN;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rx_s[u][k+1] <= xn;
					ry_s[u][k+1] <= yn;
					rz_s[u][k+1] <= zn;
					rf_s[u][k+1] <= rf_s[u][k];
				end
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_rot_eq
		always_ff @(posedge clk) begin
			if (en)
				req_s[k+1] <= req_s[k];
		end
	end

	// Stage 5: apply the cosine sign flip.
	logic signed [XW-1:0] sn_s5 [3];
	logic signed [XW-1:0] cs_s5 [3];
	logic                 eq_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int u = 0; u < 3; u++) begin
				sn_s5[u] <= ry_s[u][N];
				cs_s5[u] <= rf_s[u][N] ? -rx_s[u][N] : rx_s[u][N];
			end
			eq_s5 <= req_s[N];
		end
	end

	// Stage 6: latitude products.
	logic signed [2*XW-1:0] pss_full, pcc_full, pccd_full;
	logic signed [XW-1:0]   pss_s6, pcc_s6, cd_s6;
	logic                   eq_s6;

	assign pss_full = sn_s5[0] * sn_s5[1];
	assign pcc_full = cs_s5[0] * cs_s5[1];

	always_ff @(posedge clk) begin
		if (en) begin
			pss_s6 <= XW'(pss_full >>> 30);
			pcc_s6 <= XW'(pcc_full >>> 30);
			cd_s6  <= cs_s5[2];
			eq_s6  <= eq_s5;
		end
	end

	// Stage 7: scale by the cosine of the longitude difference.
	logic signed [XW-1:0] pss_s7, pccd_s7;
	logic                 eq_s7;

	assign pccd_full = pcc_s6 * cd_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pss_s7  <= pss_s6;
			pccd_s7 <= XW'(pccd_full >>> 30);
			eq_s7   <= eq_s6;
		end
	end

	// Stage 8: sum and clamp to [-1, 1].
	logic signed [34:0]   csum;
	logic signed [CW-1:0] c_s8;
	logic                 eq_s8;

	assign csum = 35'(pss_s7) + 35'(pccd_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			if (csum > ONE_S)
				c_s8 <= CW'(ONE_S);
			else if (csum < -ONE_S)
				c_s8 <= CW'(-ONE_S);
			else
				c_s8 <= CW'(csum);
			eq_s8 <= eq_s7;
		end
	end

	// Stage 9: square of the cosine.
	logic [30:0]          cmag;
	logic [61:0]          csq_s9;
	logic signed [CW-1:0] c_s9;
	logic                 eq_s9;

	assign cmag = c_s8[CW-1] ? 31'(-c_s8) : 31'(c_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s9 <= cmag * cmag;
			c_s9   <= c_s8;
			eq_s9  <= eq_s8;
		end
	end

	// Square-root pipe for the sine of the central angle.
	logic [QW-1:0]        qv_s [SQ_STEPS+1];
	logic [QW-1:0]        qr_s [SQ_STEPS+1];
	logic signed [CW-1:0] qc_s [SQ_STEPS+1];
	logic                 qeq_s [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			qv_s[0]  <= (QW'(1) << 60) - QW'(csq_s9);
			qr_s[0]  <= '0;
			qc_s[0]  <= c_s9;
			qeq_s[0] <= eq_s9;
		end
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam logic [QW-1:0] BIT = QW'(1) << (2 * (SQ_STEPS - 1 - j));
		logic [QW-1:0] trial;

		assign trial = qr_s[j] + BIT;

		// Take one result bit when the trial fits.
		always_ff @(posedge clk) begin
			if (en) begin
				if (qv_s[j] >= trial) begin
					qv_s[j+1] <= qv_s[j] - trial;
					qr_s[j+1] <= (qr_s[j] >> 1) + BIT;
				end else begin
					qv_s[j+1] <= qv_s[j];
					qr_s[j+1] <= qr_s[j] >> 1;
				end
				qc_s[j+1]  <= qc_s[j];
				qeq_s[j+1] <= qeq_s[j];
			end
		end
	end

	// Arccosine by CORDIC vectoring on (c, s).
	logic signed [XW-1:0] vx_s [N+1];
	logic signed [XW-1:0] vy_s [N+1];
	logic signed [ZW-1:0] vz_s [N+1];
	logic                 veq_s [N+1];
	logic signed [XW-1:0] sq_root;
	logic signed [XW-1:0] cx;

	assign sq_root = $signed({1'b0, qr_s[SQ_STEPS][XW-2:0]});
	assign cx      = XW'(qc_s[SQ_STEPS]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!cx[XW-1]) begin
				vx_s[0] <= cx;
				vy_s[0] <= sq_root;
				vz_s[0] <= '0;
			end else begin
				vx_s[0] <= sq_root;
				vy_s[0] <= -cx;
				vz_s[0] <= PI_Q60 >>> 1;
			end
			veq_s[0] <= qeq_s[SQ_STEPS];
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_vec
		localparam logic signed [ZW-1:0] ATN = atan_q60(k);
		logic signed [XW-1:0] xn, yn;
		logic signed [ZW-1:0] zn;

		// Rotate the vector onto the x axis, accumulating the angle.
		always_comb begin
			if (!vy_s[k][XW-1]) begin
				xn = vx_s[k] + (vy_s[k] >>> k);
				yn = vy_s[k] - (vx_s[k] >>> k);
				zn = vz_s[k] + ATN;
			end else begin
				xn = vx_s[k] - (vy_s[k] >>> k);
				yn = vy_s[k] + (vx_s[k] >>> k);
				zn = vz_s[k] - ATN;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vx_s[k+1]  <= xn;
				vy_s[k+1]  <= yn;
				vz_s[k+1]  <= zn;
				veq_s[k+1] <= veq_s[k];
			end
		end
	end

	// Stage 11: clamp the angle to [0, pi] and split it for scaling.
	logic signed [ZW-1:0] zc;
	logic [28:0]          hi_s11, lo_s11;
	logic                 eq_s11;

	always_comb begin
		if (vz_s[N][ZW-1])
			zc = '0;
		else if (vz_s[N] > PI_Q60)
			zc = PI_Q60;
		else
			zc = vz_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s11 <= zc[61:33];
			lo_s11 <= zc[32:4];
			eq_s11 <= veq_s[N];
		end
	end

	// Stage 12: partial products of the meter scale.
	logic [62:0] lo_prod;
	logic [62:0] ph_s12;
	logic [33:0] pl_s12;
	logic        eq_s12;

	assign lo_prod = lo_s11 * SCALE_Q;

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s12 <= hi_s11 * SCALE_Q;
			pl_s12 <= lo_prod[62:29];
			eq_s12 <= eq_s11;
		end
	end

	// Final sum, saturation and the equal-point override.
	logic [63:0] dsum;
	logic [33:0] dist_raw;
	logic [32:0] res;
	logic        last_v;

	assign dsum     = {1'b0, ph_s12} + 64'(pl_s12);
	assign dist_raw = dsum[63:30];
	assign last_v   = pipe_v_q[LAT-1];

	always_comb begin
		if (eq_s12)
			res = '0;
		else if (dist_raw > 34'(DIST_MAX))
			res = DIST_MAX;
		else
			res = dist_raw[32:0];
	end

	// Advance valid bits and steer results to the output or skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_v_q <= '0;
			ov_q     <= 1'b0;
			sk_v_q   <= 1'b0;
		end else begin
			if (en)
				pipe_v_q <= {pipe_v_q[LAT-2:0], s_tvalid};
			if (en && last_v) begin
				if (!ov_q || m_tready)
					ov_q <= 1'b1;
				else
					sk_v_q <= 1'b1;
			end else if (!ov_q || m_tready) begin
				if (sk_v_q) begin
					ov_q   <= 1'b1;
					sk_v_q <= 1'b0;
				end else begin
					ov_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && last_v) begin
			if (!ov_q || m_tready)
				out_q <= res;
			else
				sk_q <= res;
		end else if ((!ov_q || m_tready) && sk_v_q) begin
			out_q <= sk_q;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {7'd0, out_q};

	// A parked result implies the output register is also occupied.
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> ov_q)
		else $error("skid register full while output register empty");

	// The skid register fills only behind a stalled output transfer.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(ov_q && !m_tready))
		else $error("skid register filled without an output stall");

	// No distance beyond half the circumference.
	a_dist_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[32:0] <= DIST_MAX))
		else $error("distance above half circumference");

endmodule
